@@ rtl/core/vna_pkg.sv @@
// ----------------------------------------------------------------------------
// vna_pkg
// Shared widths, command codes and payload types of the vertex normal block.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = 17;
  localparam int PROD_W  = 34;
  localparam int FACE_W  = 35;
  localparam int OUT_W   = 16;
  localparam int LIMIT_W = 16;

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_TRIANGLE = 2'd1;
  localparam logic [1:0] CMD_READ     = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  localparam logic signed [OUT_W-1:0] UNIT_ONE = 16'sd16384;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [FACE_W-1:0] x;
    logic signed [FACE_W-1:0] y;
    logic signed [FACE_W-1:0] z;
  } face_t;

endpackage

@@ rtl/core/vna_cross.sv @@
// ----------------------------------------------------------------------------
// vna_cross
// Face vector (p1-p0) x (p2-p0) on one shared 17x17 multiplier, six products.
// ----------------------------------------------------------------------------
module vna_cross (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  vna_pkg::pos_t p0,
  input  vna_pkg::pos_t p1,
  input  vna_pkg::pos_t p2,
  output logic          done,
  output vna_pkg::face_t face
);
  import vna_pkg::*;

  localparam logic [2:0] LAST_STEP = 3'd6;

  logic                     running;
  logic [2:0]               step;
  logic [2:0]               step_m1;
  logic signed [DIFF_W-1:0] ax, ay, az, bx, by, bz;
  logic signed [DIFF_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [FACE_W-1:0] prod_ext;

  assign step_m1  = step - 3'd1;
  assign prod_ext = FACE_W'(prod);

  // even steps give the positive term of a component, odd steps the negative one
  always_comb begin
    case (step)
      3'd0: begin op_a = ay; op_b = bz; end
      3'd1: begin op_a = az; op_b = by; end
      3'd2: begin op_a = az; op_b = bx; end
      3'd3: begin op_a = ax; op_b = bz; end
      3'd4: begin op_a = ax; op_b = by; end
      3'd5: begin op_a = ay; op_b = bx; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        step <= step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ax <= DIFF_W'($signed(p1.x)) - DIFF_W'($signed(p0.x));
      ay <= DIFF_W'($signed(p1.y)) - DIFF_W'($signed(p0.y));
      az <= DIFF_W'($signed(p1.z)) - DIFF_W'($signed(p0.z));
      bx <= DIFF_W'($signed(p2.x)) - DIFF_W'($signed(p0.x));
      by <= DIFF_W'($signed(p2.y)) - DIFF_W'($signed(p0.y));
      bz <= DIFF_W'($signed(p2.z)) - DIFF_W'($signed(p0.z));
    end else if (running) begin
      if (step != LAST_STEP) begin
        prod <= op_a * op_b;
      end
      if (step != 3'd0) begin
        case (step_m1[2:1])
          2'd0: face.x <= step_m1[0] ? face.x - prod_ext : prod_ext;
          2'd1: face.y <= step_m1[0] ? face.y - prod_ext : prod_ext;
          2'd2: face.z <= step_m1[0] ? face.z - prod_ext : prod_ext;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/core/vna_norm.sv @@
// ----------------------------------------------------------------------------
// vna_norm
// Iterative normalizer: scale to [2^23, 2^24), sum of squares, bitwise square
// root, then one restoring division step per cycle for each component.
// ----------------------------------------------------------------------------
module vna_norm #(
  parameter int SUM_BITS = 40
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SUM_BITS-1:0] sum_x,
  input  logic signed [SUM_BITS-1:0] sum_y,
  input  logic signed [SUM_BITS-1:0] sum_z,
  output logic                       done,
  output logic signed [15:0]         norm_x,
  output logic signed [15:0]         norm_y,
  output logic signed [15:0]         norm_z
);
  import vna_pkg::*;

  localparam int SC_W  = 24;
  localparam int SQ_W  = 52;
  localparam int LEN_W = 25;
  localparam int NUM_W = 40;
  localparam int Q_W   = 15;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_ROOT  = 3'd3;
  localparam logic [2:0] N_LOAD  = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  logic [2:0]          state;
  logic [1:0]          cnt;
  logic [3:0]          kq;
  logic [SUM_BITS-1:0] mag [3];
  logic                neg [3];
  logic [2*SC_W-1:0]   prod;
  logic [SQ_W-1:0]     sq;
  logic [SQ_W-1:0]     rem_v;
  logic [SQ_W-1:0]     root;
  logic [SQ_W-1:0]     bitv;
  logic [SQ_W-1:0]     trial;
  logic [LEN_W-1:0]    len;
  logic [NUM_W-1:0]    rem;
  logic [NUM_W-1:0]    dsh;
  logic [Q_W-1:0]      q;
  logic [Q_W-1:0]      q_next;
  logic                hi_any;
  logic                mid_any;
  logic [SC_W-1:0]     sc_sel;
  logic [OUT_W-1:0]    q_signed;

  assign hi_any  = (|mag[0][SUM_BITS-1:SC_W]) | (|mag[1][SUM_BITS-1:SC_W])
                 | (|mag[2][SUM_BITS-1:SC_W]);
  assign mid_any = mag[0][SC_W-1] | mag[1][SC_W-1] | mag[2][SC_W-1];
  assign sc_sel  = mag[cnt][SC_W-1:0];
  assign trial   = root + bitv;
  assign len     = root[LEN_W-1:0];
  assign dsh     = NUM_W'(len) << kq;
  assign q_next  = (rem >= dsh) ? (q | (Q_W'(1) << kq)) : q;
  assign q_signed = neg[cnt] ? OUT_W'(-OUT_W'(q_next)) : OUT_W'(q_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE:  if (start) state <= N_SHIFT;
        N_SHIFT: if (!hi_any && mid_any) state <= N_SQ;
        N_SQ:    if (cnt == 2'd3) state <= N_ROOT;
        N_ROOT:  if (bitv[0]) state <= N_LOAD;
        N_LOAD:  state <= N_DIV;
        N_DIV: begin
          if (kq == 4'd0) begin
            if (cnt == 2'd2) begin
              state <= N_IDLE;
              done  <= 1'b1;
            end else begin
              state <= N_LOAD;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        if (start) begin
          neg[0] <= sum_x[SUM_BITS-1];
          neg[1] <= sum_y[SUM_BITS-1];
          neg[2] <= sum_z[SUM_BITS-1];
          mag[0] <= sum_x[SUM_BITS-1] ? SUM_BITS'(-sum_x) : SUM_BITS'(sum_x);
          mag[1] <= sum_y[SUM_BITS-1] ? SUM_BITS'(-sum_y) : SUM_BITS'(sum_y);
          mag[2] <= sum_z[SUM_BITS-1] ? SUM_BITS'(-sum_z) : SUM_BITS'(sum_z);
          cnt    <= '0;
          sq     <= '0;
        end
      end
      N_SHIFT: begin
        // one common shift a cycle, truncating on the way down
        if (hi_any) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (!mid_any) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      N_SQ: begin
        if (cnt != 2'd3) prod <= sc_sel * sc_sel;
        if (cnt != 2'd0) sq <= sq + SQ_W'(prod);
        if (cnt == 2'd3) begin
          rem_v <= sq + SQ_W'(prod);
          root  <= '0;
          bitv  <= SQ_W'(1) << 50;
          cnt   <= '0;
        end else begin
          cnt <= cnt + 2'd1;
        end
      end
      N_ROOT: begin
        if (rem_v >= trial) begin
          rem_v <= rem_v - trial;
          root  <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
      N_LOAD: begin
        // rounded quotient: add half the length before dividing
        rem <= (NUM_W'(sc_sel) << 14) + NUM_W'(len >> 1);
        kq  <= 4'(Q_W - 1);
        q   <= '0;
      end
      N_DIV: begin
        if (rem >= dsh) rem <= rem - dsh;
        q  <= q_next;
        kq <= kq - 4'd1;
        if (kq == 4'd0) begin
          case (cnt)
            2'd0:    norm_x <= q_signed;
            2'd1:    norm_y <= q_signed;
            default: norm_z <= q_signed;
          endcase
          cnt <= cnt + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/vertex_normal_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top
// Area-weighted vertex normals over a position memory and an accumulator memory.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result, shown for one cycle with done
// high; the receiver cannot stall, so results must be taken as they come. A load
// or an unused command answers in the cycle after it is taken and leaves busy low,
// as do a triangle with a corner out of range and a read of an index out of range.
// A triangle answers after three position reads, six products on the shared
// cross-product multiplier, and a read then a write of the accumulator memory
// for each corner; a degenerate one answers when the cross product is done.
// A read answers without the normalizer when the sum is near zero, otherwise
// after it: one scaling shift per cycle, squaring of the three components,
// 26 square-root steps and a restoring division for each component.
// After reset the block holds busy while it clears the accumulator memory;
// configuration writes are taken always.
module vertex_normal_accumulator_top #(
  parameter int VERTEX_COUNT = 1024,
  parameter int SUM_BITS     = 40
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic signed [10:0] vertex_id,
  input  logic [9:0]         second_corner,
  input  logic [9:0]         third_corner,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic               normal_valid,
  output logic               face_skipped
);
  import vna_pkg::*;

  localparam int ADDR_W = $clog2(VERTEX_COUNT);
  localparam int MEM_W  = 3 * SUM_BITS;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VERTEX_COUNT - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_TRI_A  = 4'd2;
  localparam logic [3:0] S_TRI_B  = 4'd3;
  localparam logic [3:0] S_TRI_C  = 4'd4;
  localparam logic [3:0] S_TRI_D  = 4'd5;
  localparam logic [3:0] S_CROSS  = 4'd6;
  localparam logic [3:0] S_ACC_RD = 4'd7;
  localparam logic [3:0] S_ACC_WR = 4'd8;
  localparam logic [3:0] S_RD_A   = 4'd9;
  localparam logic [3:0] S_RD_B   = 4'd10;
  localparam logic [3:0] S_NORM   = 4'd11;

  logic [3:0]          state, state_next;
  logic [1:0]          ci, ci_next;
  logic [ADDR_W-1:0]   clr_addr;
  logic [ADDR_W-1:0]   corner [3];
  logic [LIMIT_W-1:0]  near_zero_limit;

  pos_t                pos_mem [VERTEX_COUNT];
  pos_t                pos_rdata;
  pos_t                p0, p1;
  logic                pos_we;
  logic [MEM_W-1:0]    sum_mem [VERTEX_COUNT];
  logic [MEM_W-1:0]    sum_rdata;
  logic [MEM_W-1:0]    sum_wdata;
  logic [ADDR_W-1:0]   sum_waddr;
  logic                sum_we;

  logic                accept;
  logic [31:0]         idx0_wide, idx1_wide, idx2_wide;
  logic                ok0, ok1, ok2;
  logic [ADDR_W-1:0]   addr0_in;

  logic signed [SUM_BITS-1:0] rsx, rsy, rsz;
  logic                face_nz, sum_nz;
  logic                cross_start, cross_done;
  face_t               face;
  logic                norm_start, norm_done;
  logic signed [15:0]  nx, ny, nz;

  logic                res_fire, res_valid, res_skip;
  logic signed [15:0]  res_x, res_y, res_z;

  function automatic logic [FACE_W-1:0] mag_face(input logic signed [FACE_W-1:0] v);
    return v[FACE_W-1] ? FACE_W'(-v) : FACE_W'(v);
  endfunction

  function automatic logic [SUM_BITS-1:0] mag_sum(input logic signed [SUM_BITS-1:0] v);
    return v[SUM_BITS-1] ? SUM_BITS'(-v) : SUM_BITS'(v);
  endfunction

  function automatic logic [SUM_BITS-1:0] sat_add(input logic signed [SUM_BITS-1:0] a,
                                                  input logic signed [FACE_W-1:0] b);
    logic signed [SUM_BITS:0] s;
    s = (SUM_BITS+1)'(a) + (SUM_BITS+1)'(b);
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      return s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end
    return s[SUM_BITS-1:0];
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign idx0_wide = 32'(vertex_id[9:0]);
  assign idx1_wide = 32'(second_corner);
  assign idx2_wide = 32'(third_corner);
  assign ok0       = !vertex_id[10] && (idx0_wide < 32'(VERTEX_COUNT));
  assign ok1       = idx1_wide < 32'(VERTEX_COUNT);
  assign ok2       = idx2_wide < 32'(VERTEX_COUNT);
  assign addr0_in  = idx0_wide[ADDR_W-1:0];

  assign rsx = sum_rdata[MEM_W-1 -: SUM_BITS];
  assign rsy = sum_rdata[2*SUM_BITS-1 -: SUM_BITS];
  assign rsz = sum_rdata[SUM_BITS-1:0];

  assign face_nz = (mag_face(face.x) <= FACE_W'(near_zero_limit))
                && (mag_face(face.y) <= FACE_W'(near_zero_limit))
                && (mag_face(face.z) <= FACE_W'(near_zero_limit));
  assign sum_nz  = (mag_sum(rsx) <= SUM_BITS'(near_zero_limit))
                && (mag_sum(rsy) <= SUM_BITS'(near_zero_limit))
                && (mag_sum(rsz) <= SUM_BITS'(near_zero_limit));

  vna_cross u_cross (
    .clk   (clk),
    .rst   (rst),
    .start (cross_start),
    .p0    (p0),
    .p1    (p1),
    .p2    (pos_rdata),
    .done  (cross_done),
    .face  (face)
  );

  vna_norm #(.SUM_BITS(SUM_BITS)) u_norm (
    .clk    (clk),
    .rst    (rst),
    .start  (norm_start),
    .sum_x  (rsx),
    .sum_y  (rsy),
    .sum_z  (rsz),
    .done   (norm_done),
    .norm_x (nx),
    .norm_y (ny),
    .norm_z (nz)
  );

  always_comb begin
    state_next  = state;
    ci_next     = ci;
    res_fire    = 1'b0;
    res_valid   = 1'b0;
    res_skip    = 1'b0;
    res_x       = '0;
    res_y       = '0;
    res_z       = '0;
    pos_we      = 1'b0;
    sum_we      = 1'b0;
    sum_waddr   = corner[ci];
    sum_wdata   = '0;
    cross_start = 1'b0;
    norm_start  = 1'b0;
    case (state)
      S_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_addr;
        if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          ci_next = 2'd0;
          case (command)
            CMD_LOAD: begin
              res_fire = 1'b1;
              pos_we   = ok0;
            end
            CMD_TRIANGLE: begin
              if (ok0 && ok1 && ok2) begin
                state_next = S_TRI_A;
              end else begin
                res_fire = 1'b1;
                res_skip = 1'b1;
              end
            end
            CMD_READ: begin
              if (ok0) begin
                state_next = S_RD_A;
              end else begin
                res_fire  = 1'b1;
                res_valid = 1'b1;
                res_z     = UNIT_ONE;
              end
            end
            default: res_fire = 1'b1;
          endcase
        end
      end
      S_TRI_A: begin
        ci_next    = 2'd1;
        state_next = S_TRI_B;
      end
      S_TRI_B: begin
        ci_next    = 2'd2;
        state_next = S_TRI_C;
      end
      S_TRI_C: begin
        ci_next    = 2'd0;
        state_next = S_TRI_D;
      end
      S_TRI_D: begin
        cross_start = 1'b1;
        state_next  = S_CROSS;
      end
      S_CROSS: begin
        if (cross_done) begin
          if (face_nz) begin
            res_fire   = 1'b1;
            res_skip   = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_ACC_RD;
          end
        end
      end
      S_ACC_RD: state_next = S_ACC_WR;
      S_ACC_WR: begin
        // write back before the next corner is read, so repeated corners see it
        sum_we    = 1'b1;
        sum_wdata = {sat_add(rsx, face.x), sat_add(rsy, face.y), sat_add(rsz, face.z)};
        if (ci == 2'd2) begin
          res_fire   = 1'b1;
          state_next = S_IDLE;
        end else begin
          ci_next    = ci + 2'd1;
          state_next = S_ACC_RD;
        end
      end
      S_RD_A: state_next = S_RD_B;
      S_RD_B: begin
        if (sum_nz) begin
          res_fire   = 1'b1;
          res_valid  = 1'b1;
          res_z      = UNIT_ONE;
          state_next = S_IDLE;
        end else begin
          norm_start = 1'b1;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (norm_done) begin
          res_fire   = 1'b1;
          res_valid  = 1'b1;
          res_x      = nx;
          res_y      = ny;
          res_z      = nz;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      ci              <= '0;
      clr_addr        <= '0;
      done            <= 1'b0;
      normal_valid    <= 1'b0;
      face_skipped    <= 1'b0;
      near_zero_limit <= '0;
    end else begin
      state        <= state_next;
      ci           <= ci_next;
      done         <= res_fire;
      normal_valid <= res_valid;
      face_skipped <= res_skip;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_valid && cfg_ready) near_zero_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      corner[0] <= addr0_in;
      corner[1] <= idx1_wide[ADDR_W-1:0];
      corner[2] <= idx2_wide[ADDR_W-1:0];
    end
    if (state == S_TRI_B) p0 <= pos_rdata;
    if (state == S_TRI_C) p1 <= pos_rdata;
    if (res_fire) begin
      normal_x <= res_x;
      normal_y <= res_y;
      normal_z <= res_z;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[addr0_in] <= '{x: coord_x, y: coord_y, z: coord_z};
    pos_rdata <= pos_mem[corner[ci]];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rdata <= sum_mem[corner[ci]];
  end

endmodule

@@ rtl/core/vna_checker.sv @@
// ----------------------------------------------------------------------------
// vna_checker
// Port-level checks on the result strobe and its fields, bound to the top level.
// ----------------------------------------------------------------------------
module vna_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         command,
  input logic               done,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic               normal_valid,
  input logic               face_skipped
);
  import vna_pkg::*;

  // flags only travel with a result
  a_flags_need_done: assert property (@(posedge clk) disable iff (rst)
    !done |-> !normal_valid && !face_skipped)
    else $error("result flag without done");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(normal_valid && face_skipped))
    else $error("read and skipped flags together");

  a_zero_when_not_read: assert property (@(posedge clk) disable iff (rst)
    done && !normal_valid |-> normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0)
    else $error("normal nonzero on a non-read result");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done && normal_valid |->
      normal_x <= UNIT_ONE && normal_x >= -UNIT_ONE &&
      normal_y <= UNIT_ONE && normal_y >= -UNIT_ONE &&
      normal_z <= UNIT_ONE && normal_z >= -UNIT_ONE)
    else $error("normal component beyond unit");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command == CMD_LOAD || command == CMD_NONE) |=>
      done && !normal_valid && !face_skipped)
    else $error("load or unused command did not answer next cycle");

endmodule

bind vertex_normal_accumulator_top vna_checker u_vna_checker (.*);
